>>> src/sevq_pkg.sv
// ============================================================================
// sevq_pkg
// Shared types and codes for the sorted event queue.
// ============================================================================
package sevq_pkg;

    localparam int TIME_W   = 32;
    localparam int TAG_W    = 8;
    localparam int KIND_W   = 2;
    localparam int LENGTH_W = 16;
    localparam int OCC_W    = 5;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0]   finish_time;
        logic [TAG_W-1:0]    job_tag;
        logic [KIND_W-1:0]   request_kind;
        logic [LENGTH_W-1:0] busy_length;
    } event_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_pop;
    } cell_cmd_t;

endpackage

>>> src/sorted_event_queue.sv
// ============================================================================
// sorted_event_queue
// Bounded priority queue of timed events held in a sorted shift chain.
// ============================================================================
// The result strobe (done) is registered and rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, since every cell
//   compares against the new key in parallel and shifts in the same cycle.
// Reset: rst_n clears the event count and the result strobe; slot contents
//   stay undefined and are never read before being written.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_event_queue
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [sevq_pkg::TIME_W-1:0]   finish_time,
    input  logic [sevq_pkg::TAG_W-1:0]    job_tag,
    input  logic [sevq_pkg::KIND_W-1:0]   request_kind,
    input  logic [sevq_pkg::LENGTH_W-1:0] busy_length,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [sevq_pkg::TIME_W-1:0]   out_finish_time,
    output logic [sevq_pkg::TAG_W-1:0]    out_job_tag,
    output logic [sevq_pkg::KIND_W-1:0]   out_request_kind,
    output logic [sevq_pkg::LENGTH_W-1:0] out_busy_length,
    output logic [sevq_pkg::OCC_W-1:0]    occupancy
);
    import sevq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // ---- request decode ----------------------------------------------------
    logic      accept;
    logic      full;
    logic      empty;
    cell_cmd_t cmd;
    event_t    new_event;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);

    assign cmd.do_insert = accept && (operation == OP_INSERT) && !full;
    assign cmd.do_pop    = accept && (operation == OP_POP) && !empty;

    assign new_event.finish_time  = finish_time;
    assign new_event.job_tag      = job_tag;
    assign new_event.request_kind = request_kind;
    assign new_event.busy_length  = busy_length;

    // ---- cell chain --------------------------------------------------------
    // sel[i] is cell i-1's "at or behind insert point"; sel[0] is the head
    // boundary and is always clear, so the first selected cell loads the
    // new event and all cells behind it take their left neighbor.
    logic   sel [0:QUEUE_DEPTH];
    event_t slot_q [0:QUEUE_DEPTH-1];

    assign sel[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            event_t left_ev;
            event_t right_ev;
            logic   occ;

            assign occ = (CW'(g) < count_reg);

            if (g == 0)
            begin : g_head
                assign left_ev = new_event;
            end
            else
            begin : g_body
                assign left_ev = slot_q[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_ev = slot_q[g];
            end
            else
            begin : g_mid
                assign right_ev = slot_q[g+1];
            end

            sevq_cell u_cell
            (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occ),
                .new_event  (new_event),
                .left_event (left_ev),
                .right_event(right_ev),
                .left_sel   (sel[g]),
                .sel        (sel[g+1]),
                .slot_event (slot_q[g])
            );
        end
    endgenerate

    // ---- count -------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // ---- result register ---------------------------------------------------
    logic    done_reg;
    status_t status_reg;
    status_t status_next;
    event_t  result_reg;
    event_t  result_next;
    logic [OCC_W-1:0] occ_reg;

    always_comb
    begin
        status_next = STATUS_OK;
        result_next = '0;
        if (operation == OP_INSERT)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
        end
        else if (empty)
        begin
            status_next = STATUS_EMPTY;
        end
        else
        begin
            result_next = slot_q[0];    // head leaves on a pop
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign out_finish_time  = result_reg.finish_time;
    assign out_job_tag      = result_reg.job_tag;
    assign out_request_kind = result_reg.request_kind;
    assign out_busy_length  = result_reg.busy_length;
    assign occupancy        = occ_reg;

    // ---- assertions --------------------------------------------------------
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result strobe without a request");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("event count above queue depth");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == STATUS_FULL) |-> occ_reg == OCC_W'(QUEUE_DEPTH))
        else $error("full status with queue not full");

    a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == STATUS_EMPTY) |-> occ_reg == '0)
        else $error("empty status with queue not empty");

endmodule

>>> src/sevq_cell.sv
// ============================================================================
// sevq_cell
// One slot of the sorted chain: compares, then holds, shifts or loads.
// ============================================================================
module sevq_cell
(
    input  logic              clk,
    input  sevq_pkg::cell_cmd_t cmd,
    input  logic              occupied,
    input  sevq_pkg::event_t  new_event,
    input  sevq_pkg::event_t  left_event,
    input  sevq_pkg::event_t  right_event,
    input  logic              left_sel,
    output logic              sel,
    output sevq_pkg::event_t  slot_event
);
    import sevq_pkg::*;

    event_t slot_reg;
    event_t slot_next;

    // at or behind the insert point: free slot, or strictly later time
    assign sel = occupied ? (new_event.finish_time < slot_reg.finish_time) : 1'b1;

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.do_insert && sel)
        begin
            slot_next = left_sel ? left_event : new_event;
        end
        else if (cmd.do_pop)
        begin
            slot_next = right_event;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_event = slot_reg;

endmodule
